>>> hdl/wind_frequency_matrix_defines.svh
// Assertion macros shared by the modules of the wind frequency matrix.
`ifndef WIND_FREQUENCY_MATRIX_DEFINES_SVH
`define WIND_FREQUENCY_MATRIX_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define WFM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define WFM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/wfm_pkg.sv
package wfm_pkg;

	localparam int THRESHOLD_COUNT = 7;
	localparam int OP_ADD = 0;
	localparam int OP_QUERY = 1;

	typedef struct packed {
		logic        operation;
		logic        cold_season;
		logic [4:0]  direction;
		logic [2:0]  stability_class;
		logic [15:0] wind_speed;
		logic [2:0]  query_grade;
	} in_item_t;

	typedef struct packed {
		logic        input_error;
		logic [31:0] cell_count;
		logic [15:0] cell_weight;
		logic [15:0] rose_fraction;
		logic [15:0] grade_fraction;
		logic [15:0] class_fraction;
		logic [15:0] calm_fraction;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic clear_step;
		logic add_cell_rd;
		logic add_cell_wr;
		logic add_marg;
		logic q_cell_rd;
		logic q_cell_latch;
		logic calm_rd;
		logic calm_acc;
		logic mul_start;
		logic div_start;
		logic [2:0] div_sel;
		logic emit;
		logic emit_error;
	} wfm_cmd_t;

	typedef struct packed {
		logic item_error;
		logic item_query;
		logic clear_done;
		logic calm_last;
		logic mul_done;
		logic div_done;
	} wfm_status_t;

	localparam logic [2:0] DIV_WEIGHT = 3'd0;
	localparam logic [2:0] DIV_ROSE   = 3'd1;
	localparam logic [2:0] DIV_GRADE  = 3'd2;
	localparam logic [2:0] DIV_CLASS  = 3'd3;
	localparam logic [2:0] DIV_CALM   = 3'd4;

endpackage

>>> hdl/wfm_ctrl.sv
`include "wind_frequency_matrix_defines.svh"

module wfm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	output wfm_pkg::wfm_cmd_t    cmd,
	input  wfm_pkg::wfm_status_t status
);

	localparam logic [3:0] ST_CLEAR   = 4'd0;
	localparam logic [3:0] ST_IDLE    = 4'd1;
	localparam logic [3:0] ST_CHECK   = 4'd2;
	localparam logic [3:0] ST_ADD_RD  = 4'd3;
	localparam logic [3:0] ST_ADD_WR  = 4'd4;
	localparam logic [3:0] ST_Q_RD    = 4'd5;
	localparam logic [3:0] ST_Q_LATCH = 4'd6;
	localparam logic [3:0] ST_CALM_RD = 4'd7;
	localparam logic [3:0] ST_CALM_AC = 4'd8;
	localparam logic [3:0] ST_MUL     = 4'd9;
	localparam logic [3:0] ST_DIV_GO  = 4'd10;
	localparam logic [3:0] ST_DIV     = 4'd11;
	localparam logic [3:0] ST_EMIT    = 4'd12;

	logic [3:0] state_q, state_d;
	logic [2:0] sel_q, sel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			sel_q   <= '0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		sel_d   = sel_q;
		cmd     = '0;
		cmd.div_sel = sel_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (status.clear_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.item_error) begin
					cmd.emit = 1'b1;
					cmd.emit_error = 1'b1;
					state_d = ST_IDLE;
				end else if (status.item_query) begin
					state_d = ST_Q_RD;
				end else begin
					state_d = ST_ADD_RD;
				end
			end
			ST_ADD_RD: begin
				cmd.add_cell_rd = 1'b1;
				state_d = ST_ADD_WR;
			end
			ST_ADD_WR: begin
				cmd.add_cell_wr = 1'b1;
				cmd.add_marg = 1'b1;
				cmd.emit = 1'b1;
				state_d = ST_IDLE;
			end
			ST_Q_RD: begin
				cmd.q_cell_rd = 1'b1;
				state_d = ST_Q_LATCH;
			end
			ST_Q_LATCH: begin
				cmd.q_cell_latch = 1'b1;
				state_d = ST_CALM_RD;
			end
			ST_CALM_RD: begin
				cmd.calm_rd = 1'b1;
				state_d = ST_CALM_AC;
			end
			ST_CALM_AC: begin
				cmd.calm_acc = 1'b1;
				if (status.calm_last) begin
					cmd.mul_start = 1'b1;
					state_d = ST_MUL;
				end else begin
					state_d = ST_CALM_RD;
				end
			end
			ST_MUL: begin
				if (status.mul_done) begin
					sel_d = wfm_pkg::DIV_WEIGHT;
					state_d = ST_DIV_GO;
				end
			end
			ST_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (status.div_done) begin
					if (sel_q == wfm_pkg::DIV_CALM) begin
						state_d = ST_EMIT;
					end else begin
						sel_d = sel_q + 3'd1;
						state_d = ST_DIV_GO;
					end
				end
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`WFM_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "item accepted but not busy")
	`WFM_ASSERT_IMPL(a_emit_busy, clk, arst_n, cmd.emit, busy, "result while idle")
	`WFM_ASSERT_IMPL(a_div_sel, clk, arst_n, cmd.div_start, sel_q <= wfm_pkg::DIV_CALM, "bad divide select")

endmodule

>>> hdl/wfm_div.sv
`include "wind_frequency_matrix_defines.svh"

module wfm_div #(
	parameter int NUM_WIDTH = 64,
	parameter int FRACTION_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     go,
	input  logic [NUM_WIDTH-1:0]     num,
	input  logic [NUM_WIDTH-1:0]     den,
	output logic                     done,
	output logic [FRACTION_BITS-1:0] quo
);

	localparam int CW = $clog2(FRACTION_BITS + 1);

	logic [NUM_WIDTH:0]       rem_q;
	logic [NUM_WIDTH-1:0]     den_q;
	logic [FRACTION_BITS-1:0] quo_q;
	logic [CW-1:0]            cnt_q;
	logic                     run_q;
	logic                     done_q;
	logic [NUM_WIDTH:0]       shifted;
	logic                     ge;

	assign shifted = {rem_q[NUM_WIDTH-1:0], 1'b0};
	assign ge = (shifted >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				if (den == '0) begin
					done_q <= 1'b1;
				end else if (num >= den) begin
					done_q <= 1'b1;
				end else begin
					run_q <= 1'b1;
					cnt_q <= CW'(FRACTION_BITS);
				end
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			if (den == '0) quo_q <= '0;
			else if (num >= den) quo_q <= '1;
			else quo_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? (shifted - {1'b0, den_q}) : shifted;
			quo_q <= {quo_q[FRACTION_BITS-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

	`WFM_ASSERT_IMPL(a_done_idle, clk, arst_n, done, !run_q, "divider done while running")
	`WFM_ASSERT_NEXT(a_go_state, clk, arst_n, go, run_q || done, "divider lost start")
	`WFM_ASSERT_IMPL(a_cnt_range, clk, arst_n, run_q, cnt_q != '0, "divider count empty")

endmodule

>>> hdl/wfm_data.sv
module wfm_data #(
	parameter int DIRECTIONS = 16,
	parameter int CLASSES = 7,
	parameter int GRADES = 8,
	parameter int COUNT_WIDTH = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  wfm_pkg::in_item_t          item,
	input  logic [wfm_pkg::THRESHOLD_COUNT-1:0][15:0] thresholds,
	input  wfm_pkg::wfm_cmd_t          cmd,
	output wfm_pkg::wfm_status_t       status,
	output logic                       result_valid,
	output wfm_pkg::out_item_t         result
);

	localparam int DW = $clog2(DIRECTIONS);
	localparam int CLW = (CLASSES > 1) ? $clog2(CLASSES) : 1;
	localparam int GW = $clog2(GRADES);
	localparam int DEPTH = 2 * DIRECTIONS * CLASSES * GRADES;
	localparam int AW = $clog2(DEPTH);
	localparam int NW = 2 * COUNT_WIDTH;
	localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

	wfm_pkg::in_item_t item_q;
	logic [GW-1:0]  grade_q;
	logic [DW-1:0]  sector;
	logic [AW-1:0]  addr;
	logic [AW-1:0]  clr_addr_q;
	logic [CLW-1:0] calm_cls_q;
	logic [COUNT_WIDTH-1:0] mem [DEPTH];
	logic [COUNT_WIDTH-1:0] rd_q;
	logic [COUNT_WIDTH-1:0] cell_q;
	logic [COUNT_WIDTH-1:0] calm0_q;
	logic [COUNT_WIDTH+3:0] calm_sum_q;

	logic [1:0][COUNT_WIDTH-1:0] tot_q, noncalm_q, g1tot_q;
	logic [2*DIRECTIONS-1:0][COUNT_WIDTH-1:0] dir_nc_q, dir_g1_q;
	logic [2*CLASSES-1:0][COUNT_WIDTH-1:0] cls_q;
	logic [2*GRADES-1:0][COUNT_WIDTH-1:0] grd_q;

	logic [GW-1:0] grade_calc;
	logic [2:0] k_raw;
	logic s;
	logic [DW:0] dix;
	logic [DW:0] dsx;
	logic [CLW:0] cix;
	logic [GW:0] gix;
	logic [COUNT_WIDTH-1:0] tot_s, g1_dir, g1_tot;

	logic [1:0]    mul_ph_q;
	logic [NW-1:0] div_num, div_den;
	logic          div_done;
	logic [FRACTION_BITS-1:0] div_quo;
	logic [FRACTION_BITS-1:0] frac_q [5];
	wfm_pkg::out_item_t res_d;

	always_comb begin
		k_raw = 3'(wfm_pkg::THRESHOLD_COUNT);
		for (int i = wfm_pkg::THRESHOLD_COUNT - 1; i >= 0; i--) begin
			if (item_q.wind_speed < thresholds[i]) k_raw = 3'(i);
		end
		grade_calc = (k_raw > 3'(GRADES - 1)) ? GW'(GRADES - 1) : k_raw[GW-1:0];
	end

	assign s = item_q.cold_season;
	assign dix = (item_q.direction == '0) ? '0 : (DW + 1)'(item_q.direction - 5'd1);
	assign sector = dix[DW-1:0];
	assign dsx = (DW + 1)'(32'(s) * DIRECTIONS + 32'(sector));
	assign cix = (CLW + 1)'(32'(s) * CLASSES + 32'(item_q.stability_class[CLW-1:0]));
	assign gix = (GW + 1)'(32'(s) * GRADES + 32'(grade_q));

	function automatic logic [COUNT_WIDTH-1:0] inc(input logic [COUNT_WIDTH-1:0] v);
		return (v == CMAX) ? v : v + 1'b1;
	endfunction

	always_comb begin
		addr = AW'(((({31'd0, s} * DIRECTIONS + 32'(sector)) * CLASSES
			+ 32'(item_q.stability_class)) * GRADES) + 32'(grade_q));
		if (cmd.calm_rd) begin
			addr = AW'((({31'd0, s} * DIRECTIONS) * CLASSES + 32'(calm_cls_q)) * GRADES);
		end
		if (cmd.clear_step) addr = clr_addr_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_step) mem[addr] <= '0;
		else if (cmd.add_cell_wr) mem[addr] <= inc(rd_q);
		rd_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			tot_q <= '0;
			noncalm_q <= '0;
			g1tot_q <= '0;
			dir_nc_q <= '0;
			dir_g1_q <= '0;
			cls_q <= '0;
			grd_q <= '0;
		end else begin
			if (cmd.clear_step) clr_addr_q <= clr_addr_q + 1'b1;
			if (cmd.add_marg) begin
				tot_q[s] <= inc(tot_q[s]);
				cls_q[cix] <= inc(cls_q[cix]);
				grd_q[gix] <= inc(grd_q[gix]);
				if (grade_q != '0) begin
					noncalm_q[s] <= inc(noncalm_q[s]);
					dir_nc_q[dsx] <= inc(dir_nc_q[dsx]);
				end
				if (grade_q == GW'(1)) begin
					g1tot_q[s] <= inc(g1tot_q[s]);
					dir_g1_q[dsx] <= inc(dir_g1_q[dsx]);
				end
			end
		end
	end

	assign status.clear_done = (32'(clr_addr_q) == DEPTH - 1);
	assign status.item_error = (32'(item_q.direction) > DIRECTIONS)
		|| (32'(item_q.stability_class) >= CLASSES)
		|| (item_q.operation && (32'(item_q.query_grade) >= GRADES));
	assign status.item_query = item_q.operation;
	assign status.calm_last = (32'(calm_cls_q) == CLASSES - 1);

	assign tot_s  = tot_q[s];
	assign g1_dir = dir_g1_q[dsx];
	assign g1_tot = g1tot_q[s];

	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= item;
		if (cmd.load) calm_cls_q <= '0;
		else if (cmd.calm_acc) calm_cls_q <= calm_cls_q + 1'b1;
		if (cmd.q_cell_rd) calm_sum_q <= '0;
		else if (cmd.calm_acc) calm_sum_q <= calm_sum_q + (COUNT_WIDTH + 4)'(rd_q);
		if (cmd.calm_acc && calm_cls_q == item_q.stability_class[CLW-1:0]) calm0_q <= rd_q;
		if (cmd.q_cell_latch) cell_q <= rd_q;
		if (!cmd.calm_rd && !cmd.calm_acc && !cmd.q_cell_rd && !cmd.q_cell_latch
			&& !cmd.add_cell_rd && !cmd.add_cell_wr)
			grade_q <= item_q.operation ? item_q.query_grade[GW-1:0] : grade_calc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_ph_q <= '0;
		end else if (cmd.mul_start) begin
			mul_ph_q <= 2'd1;
		end else if (mul_ph_q != 2'd0) begin
			mul_ph_q <= (mul_ph_q == 2'd2) ? 2'd0 : mul_ph_q + 2'd1;
		end
	end

	logic [NW-1:0] prod_num_q, prod_den_q;

	always_ff @(posedge clk) begin
		if (mul_ph_q == 2'd1) prod_num_q <= NW'(calm0_q) * NW'(g1_dir);
		if (mul_ph_q == 2'd2) prod_den_q <= NW'(tot_s) * NW'(g1_tot);
	end

	assign status.mul_done = (mul_ph_q == 2'd2);

	always_comb begin
		div_num = '0;
		div_den = NW'(tot_s);
		unique case (cmd.div_sel)
			wfm_pkg::DIV_WEIGHT: begin
				if (grade_q == '0) begin
					div_num = prod_num_q;
					div_den = prod_den_q;
				end else begin
					div_num = NW'(cell_q);
				end
			end
			wfm_pkg::DIV_ROSE: begin
				div_num = NW'(dir_nc_q[dsx]);
				div_den = NW'(noncalm_q[s]);
			end
			wfm_pkg::DIV_GRADE: div_num = NW'(grd_q[gix]);
			wfm_pkg::DIV_CLASS: div_num = NW'(cls_q[cix]);
			default: div_num = NW'(calm_sum_q);
		endcase
	end

	wfm_div #(.NUM_WIDTH(NW), .FRACTION_BITS(FRACTION_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .go(cmd.div_start), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_quo)
	);
	assign status.div_done = div_done;

	always_ff @(posedge clk) begin
		if (div_done) frac_q[cmd.div_sel] <= div_quo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.emit;
		end
	end

	always_comb begin
		res_d = '0;
		if (cmd.emit_error) begin
			res_d.input_error = 1'b1;
		end else if (item_q.operation) begin
			res_d.cell_count     = 32'(cell_q);
			res_d.cell_weight    = 16'(frac_q[wfm_pkg::DIV_WEIGHT]);
			res_d.rose_fraction  = 16'(frac_q[wfm_pkg::DIV_ROSE]);
			res_d.grade_fraction = 16'(frac_q[wfm_pkg::DIV_GRADE]);
			res_d.class_fraction = 16'(frac_q[wfm_pkg::DIV_CLASS]);
			res_d.calm_fraction  = 16'(frac_q[wfm_pkg::DIV_CALM]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) result <= res_d;
	end

endmodule

>>> hdl/wind_frequency_matrix.sv
// Each add is answered once its cell and its margin counts are updated.
// Each valid query reads its cell, then the seven calm cells, then multiplies,
// and then the bit-serial divider forms five fractions in turn, each ending
// early when the denominator is zero or the ratio saturates. An invalid item
// is answered straight from the check of its fields. After reset the block
// holds busy while it clears every entry of the cell table, one entry a cycle.
// Each result shows on result for one cycle with result_valid
// high and must be taken then, since the receiver cannot stall.
module wind_frequency_matrix #(
	parameter int DIRECTIONS = 16,
	parameter int CLASSES = 7,
	parameter int GRADES = 8,
	parameter int COUNT_WIDTH = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  wfm_pkg::in_item_t   item,
	output logic                result_valid,
	output wfm_pkg::out_item_t  result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic [wfm_pkg::THRESHOLD_COUNT-1:0][15:0] thr_q;
	wfm_pkg::wfm_cmd_t    cmd;
	wfm_pkg::wfm_status_t status;
	logic [2:0] ridx;

	assign pready = 1'b1;
	assign ridx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q[0] <= 16'd75;
			thr_q[1] <= 16'd150;
			thr_q[2] <= 16'd250;
			thr_q[3] <= 16'd350;
			thr_q[4] <= 16'd550;
			thr_q[5] <= 16'd750;
			thr_q[6] <= 16'd1000;
		end else if (psel && penable && pwrite && 32'(ridx) < wfm_pkg::THRESHOLD_COUNT) begin
			thr_q[ridx] <= pwdata[15:0];
		end
	end

	assign prdata = (32'(ridx) < wfm_pkg::THRESHOLD_COUNT) ? {16'd0, thr_q[ridx]} : 32'd0;

	wfm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd), .status(status)
	);

	wfm_data #(
		.DIRECTIONS(DIRECTIONS), .CLASSES(CLASSES), .GRADES(GRADES),
		.COUNT_WIDTH(COUNT_WIDTH), .FRACTION_BITS(FRACTION_BITS)
	) u_data (
		.clk(clk), .arst_n(arst_n), .item(item), .thresholds(thr_q), .cmd(cmd),
		.status(status), .result_valid(result_valid), .result(result)
	);

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int NDIR = 16;
	localparam int NCLS = 7;
	localparam int NGRD = 8;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	wfm_pkg::in_item_t item;
	logic result_valid;
	wfm_pkg::out_item_t result;
	logic psel, penable, pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	wind_frequency_matrix dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.result_valid(result_valid), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Model state of the frequency table.
	logic [15:0] speed_bounds [wfm_pkg::THRESHOLD_COUNT];
	logic [31:0] cells [2][NDIR][NCLS][NGRD];
	logic [31:0] tot [2];
	logic [31:0] noncalm_tot [2];
	logic [31:0] dir_noncalm [2][NDIR];
	logic [31:0] dir_g1 [2][NDIR];
	logic [31:0] g1_tot [2];
	logic [31:0] cls_cnt [2][NCLS];
	logic [31:0] grd_cnt [2][NGRD];

	wfm_pkg::in_item_t pending_items [$];
	wfm_pkg::out_item_t expected_results [$];

	int mismatches = 0;
	int beats_out = 0;
	int beats_in = 0;
	int idle_cycles = 0;
	bit hold_sender = 0;
	int gap_left = 0;
	int burst_left = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] sat_inc(logic [31:0] c);
		return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
	endfunction

	function automatic logic [15:0] q16(logic [63:0] num, logic [63:0] den);
		logic [63:0] quo;
		if (den == 0)
			return 16'd0;
		if (num >= den)
			return 16'hFFFF;
		quo = 64'({num, 16'd0} / {16'd0, den});
		return quo[15:0];
	endfunction

	function automatic wfm_pkg::out_item_t predict_tally(wfm_pkg::in_item_t it);
		wfm_pkg::out_item_t r;
		int s, n, j, k;
		logic [63:0] calm;
		r = '0;
		if (it.direction > NDIR || it.stability_class >= NCLS ||
				(it.operation == wfm_pkg::OP_QUERY && it.query_grade >= NGRD)) begin
			r.input_error = 1'b1;
			return r;
		end
		s = it.cold_season;
		n = (it.direction == 0) ? 0 : it.direction - 1;
		j = it.stability_class;
		if (it.operation == wfm_pkg::OP_ADD) begin
			k = 7;
			for (int i = 0; i < wfm_pkg::THRESHOLD_COUNT; i++) begin
				if (it.wind_speed < speed_bounds[i]) begin
					k = i;
					break;
				end
			end
			if (k > NGRD - 1)
				k = NGRD - 1;
			cells[s][n][j][k] = sat_inc(cells[s][n][j][k]);
			tot[s] = sat_inc(tot[s]);
			cls_cnt[s][j] = sat_inc(cls_cnt[s][j]);
			grd_cnt[s][k] = sat_inc(grd_cnt[s][k]);
			if (k != 0) begin
				noncalm_tot[s] = sat_inc(noncalm_tot[s]);
				dir_noncalm[s][n] = sat_inc(dir_noncalm[s][n]);
			end
			if (k == 1) begin
				dir_g1[s][n] = sat_inc(dir_g1[s][n]);
				g1_tot[s] = sat_inc(g1_tot[s]);
			end
			return r;
		end
		k = it.query_grade;
		r.cell_count = cells[s][n][j][k];
		if (k != 0)
			r.cell_weight = q16({32'd0, cells[s][n][j][k]}, {32'd0, tot[s]});
		else
			r.cell_weight = q16(64'(cells[s][0][j][0]) * 64'(dir_g1[s][n]),
				64'(tot[s]) * 64'(g1_tot[s]));
		r.rose_fraction = q16({32'd0, dir_noncalm[s][n]}, {32'd0, noncalm_tot[s]});
		r.grade_fraction = q16({32'd0, grd_cnt[s][k]}, {32'd0, tot[s]});
		r.class_fraction = q16({32'd0, cls_cnt[s][j]}, {32'd0, tot[s]});
		calm = 0;
		for (int i = 0; i < NCLS; i++)
			calm += 64'(cells[s][0][i][0]);
		r.calm_fraction = q16(calm, {32'd0, tot[s]});
		return r;
	endfunction

	// Driver: bursts of items with random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			item <= '0;
			gap_left <= 0;
			burst_left <= 0;
		end else begin
			if (start && !busy) begin
				expected_results.push_back(predict_tally(item));
				beats_in <= beats_in + 1;
			end
			if (start && busy) begin
				start <= 1'b1;
			end else if (hold_sender || pending_items.size() == 0) begin
				start <= 1'b0;
			end else if (gap_left > 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else begin
				item <= pending_items.pop_front();
				start <= 1'b1;
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 12);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 30);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// Monitor: result beats are taken on the cycle they appear.
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			wfm_pkg::out_item_t want;
			beats_out <= beats_out + 1;
			if (expected_results.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("unexpected result beat %p", result);
			end else begin
				want = expected_results.pop_front();
				if (result !== want) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("mismatch: expected %p actual %p", want, result);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || result_valid)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("watchdog expired");
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic apb_write(input int idx, input logic [15:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'(4 * idx);
		pwdata <= {16'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		speed_bounds[idx] = val;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic wait_drained;
		while (pending_items.size() != 0 || start || expected_results.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	function automatic wfm_pkg::in_item_t rand_obs(bit noisy);
		wfm_pkg::in_item_t it;
		logic [31:0] rnd;
		rnd = $urandom;
		it = rnd[$bits(wfm_pkg::in_item_t)-1:0];
		it.operation = ($urandom_range(0, 3) == 0) ? 1'b1 : 1'b0;
		if (!noisy) begin
			it.direction = 5'($urandom_range(0, NDIR));
			it.stability_class = 3'($urandom_range(0, NCLS - 1));
			if ($urandom_range(0, 1))
				it.wind_speed = 16'($urandom_range(0, 1200));
		end
		return it;
	endfunction

	task automatic push_item(int op, int s, int d, int c, int spd, int g);
		wfm_pkg::in_item_t it;
		it.operation = 1'(op);
		it.cold_season = 1'(s);
		it.direction = 5'(d);
		it.stability_class = 3'(c);
		it.wind_speed = 16'(spd);
		it.query_grade = 3'(g);
		pending_items.push_back(it);
	endtask

	task automatic set_bounds(int kind);
		logic [15:0] v;
		for (int i = 0; i < wfm_pkg::THRESHOLD_COUNT; i++) begin
			unique case (kind)
				0: v = 16'(i * 100 + 50);
				1: v = 16'd0;
				2: v = 16'hFFFF;
				default: v = 16'($urandom);
			endcase
			apb_write(i, v);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		speed_bounds = '{75, 150, 250, 350, 550, 750, 1000};
		for (int s = 0; s < 2; s++) begin
			tot[s] = 0; noncalm_tot[s] = 0; g1_tot[s] = 0;
			for (int n = 0; n < NDIR; n++) begin
				dir_noncalm[s][n] = 0; dir_g1[s][n] = 0;
				for (int j = 0; j < NCLS; j++)
					for (int k = 0; k < NGRD; k++)
						cells[s][n][j][k] = 0;
			end
			for (int j = 0; j < NCLS; j++) cls_cnt[s][j] = 0;
			for (int k = 0; k < NGRD; k++) grd_cnt[s][k] = 0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		push_item(wfm_pkg::OP_QUERY, 0, 1, 0, 0, 1);
		push_item(wfm_pkg::OP_ADD, 0, 0, 0, 0, 0);
		push_item(wfm_pkg::OP_ADD, 0, 16, 6, 65535, 7);
		push_item(wfm_pkg::OP_ADD, 1, 3, 2, 80, 0);
		push_item(wfm_pkg::OP_ADD, 1, 3, 2, 100, 0);
		push_item(wfm_pkg::OP_ADD, 1, 0, 1, 10, 0);
		push_item(wfm_pkg::OP_ADD, 0, 17, 0, 10, 0);
		push_item(wfm_pkg::OP_ADD, 0, 31, 7, 10, 0);
		push_item(wfm_pkg::OP_ADD, 0, 2, 7, 10, 0);
		push_item(wfm_pkg::OP_QUERY, 1, 0, 1, 0, 0);
		push_item(wfm_pkg::OP_QUERY, 1, 3, 1, 0, 0);
		push_item(wfm_pkg::OP_QUERY, 1, 3, 2, 0, 1);
		push_item(wfm_pkg::OP_QUERY, 0, 16, 6, 0, 7);
		push_item(wfm_pkg::OP_QUERY, 0, 1, 0, 0, 0);
		push_item(wfm_pkg::OP_QUERY, 0, 17, 0, 0, 0);
		push_item(wfm_pkg::OP_QUERY, 0, 1, 7, 0, 0);
		push_item(wfm_pkg::OP_QUERY, 1, 16, 0, 0, 7);
		push_item(wfm_pkg::OP_ADD, 0, 5, 3, 1000, 0);
		push_item(wfm_pkg::OP_ADD, 0, 5, 3, 999, 0);
		push_item(wfm_pkg::OP_QUERY, 0, 5, 3, 12345, 7);
		wait_drained();

		for (int phase = 0; phase < 6; phase++) begin
			set_bounds(phase % 4);
			if (phase == 3)
				apb_write(6, 16'd1000);
			for (int i = 0; i < 240; i++)
				pending_items.push_back(rand_obs($urandom_range(0, 9) == 0));
			if (phase == 2) begin
				while (pending_items.size() > 120)
					@(posedge clk);
				hold_sender = 1'b1;
				while (start || expected_results.size() != 0)
					@(posedge clk);
				hold_sender = 1'b0;
			end
			wait_drained();
		end

		$display("Ran %0d items through adds, queries and invalid fields,", beats_in);
		$display("six threshold settings including all-zero and all-ones; %0d results.",
			beats_out);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("mismatches: %0d, left over: %0d", mismatches, expected_results.size());
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
